>>> hdl/rlpws_pkg.sv
package rlpws_pkg;

  localparam int COLOR_BITS  = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int PIX_BITS    = 3 * COLOR_BITS;
  localparam int LEFT_WIDTH  = $clog2(PIX_BITS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = COUNT_WIDTH'(CNT_MAX32);

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [1:0] REG_LONG  = 2'd0;
  localparam logic [1:0] REG_SHORT = 2'd1;
  localparam logic [1:0] REG_LATCH = 2'd2;

  localparam logic [CFG_WIDTH-1:0] LONG_RESET  = CFG_WIDTH'(64);
  localparam logic [CFG_WIDTH-1:0] SHORT_RESET = CFG_WIDTH'(32);
  localparam logic [CFG_WIDTH-1:0] LATCH_RESET = CFG_WIDTH'(4000);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic                kind;
    logic [PIX_BITS-1:0] pixel;
    logic                last;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic ready_res;
    logic frame_done;
    logic dropped;
  } result_t;

  // zero acts as one, values beyond the counter clamp to its maximum
  function automatic logic [COUNT_WIDTH-1:0] eff_dur(input logic [CFG_WIDTH-1:0] d);
    logic [31:0] w;
    begin
      w = 32'(d);
      if (w == 32'd0) w = 32'd1;
      if (w > CNT_MAX32) w = CNT_MAX32;
      return COUNT_WIDTH'(w);
    end
  endfunction

endpackage

>>> hdl/rlpws_front.sv
module rlpws_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [7:0]            green,
  input  logic [7:0]            red,
  input  logic [7:0]            blue,
  input  logic                  last_pixel,
  output logic                  push,
  output rlpws_pkg::item_t      push_item,
  input  logic                  push_ready
);
  import rlpws_pkg::*;

  logic  f_valid;
  item_t f_item;
  item_t dec_item;

  always_comb begin
    dec_item.kind  = kind;
    dec_item.pixel = (kind == KIND_PIXEL) ? {green, red, blue} : '0;
    dec_item.last  = (kind == KIND_PIXEL) ? last_pixel : 1'b0;
  end

  assign push      = f_valid;
  assign push_item = f_item;
  assign in_ready  = !f_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item <= dec_item;
    end
  end

endmodule

>>> hdl/rlpws_queue.sv
module rlpws_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rlpws_pkg::item_t push_item,
  output logic             push_ready,
  output logic             pop_valid,
  output rlpws_pkg::item_t pop_item,
  input  logic             pop
);
  import rlpws_pkg::*;

  item_t                 mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != QCNT_WIDTH'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) && !push |=> (count == '0))
    else $error("queue count moved without a push");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> (count == $past(count) + 1'b1))
    else $error("push not counted");

endmodule

>>> hdl/rlpws_back.sv
module rlpws_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             q_valid,
  input  rlpws_pkg::item_t q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output rlpws_pkg::result_t out_res
);
  import rlpws_pkg::*;

  logic [CFG_WIDTH-1:0]   long_ticks;
  logic [CFG_WIDTH-1:0]   short_ticks;
  logic [CFG_WIDTH-1:0]   latch_ticks;

  logic [PIX_BITS-1:0]    shift_bits, shift_bits_next;
  logic [LEFT_WIDTH-1:0]  bits_left, bits_left_next;
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [PIX_BITS-1:0]    held_pixel, held_pixel_next;
  logic                   held_valid, held_valid_next;
  logic                   held_last, held_last_next;
  logic                   current_last, current_last_next;

  logic                   bit_now;
  logic [CFG_WIDTH-1:0]   dur_cfg;
  logic [COUNT_WIDTH-1:0] dur;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_after;
  logic                   reached;
  logic [LEFT_WIDTH-1:0]  left_dec;
  logic                   take;
  logic                   done;
  logic                   drop;
  result_t                res;

  assign pop     = q_valid && (!out_valid || out_ready);
  assign bit_now = shift_bits[PIX_BITS-1];

  always_comb begin
    case (phase)
      PH_HIGH:  dur_cfg = bit_now ? long_ticks : short_ticks;
      PH_LOW:   dur_cfg = bit_now ? short_ticks : long_ticks;
      PH_LATCH: dur_cfg = latch_ticks;
      default:  dur_cfg = long_ticks;
    endcase
  end

  assign dur       = eff_dur(dur_cfg);
  assign cnt_inc   = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;
  assign reached   = (cnt_inc >= dur);
  assign cnt_after = reached ? '0 : cnt_inc;
  assign left_dec  = (bits_left != '0) ? bits_left - 1'b1 : '0;

  always_comb begin
    shift_bits_next   = shift_bits;
    bits_left_next    = bits_left;
    phase_next        = phase;
    tick_count_next   = tick_count;
    held_pixel_next   = held_pixel;
    held_valid_next   = held_valid;
    held_last_next    = held_last;
    current_last_next = current_last;
    take              = 1'b0;
    done              = 1'b0;
    drop              = 1'b0;
    if (pop) begin
      if (q_item.kind == KIND_TICK) begin
        case (phase)
          PH_HIGH: begin
            tick_count_next = cnt_after;
            if (reached) phase_next = PH_LOW;
          end
          PH_LOW: begin
            tick_count_next = cnt_after;
            if (reached) begin
              shift_bits_next = {shift_bits[PIX_BITS-2:0], 1'b0};
              bits_left_next  = left_dec;
              if (left_dec != '0) begin
                phase_next = PH_HIGH;
              end else if (current_last) begin
                current_last_next = 1'b0;
                if (latch_ticks == '0) begin
                  done       = 1'b1;
                  phase_next = PH_IDLE;
                  take       = 1'b1;
                end else begin
                  phase_next = PH_LATCH;
                end
              end else begin
                phase_next = PH_IDLE;
                take       = 1'b1;
              end
            end
          end
          PH_LATCH: begin
            tick_count_next = cnt_after;
            if (reached) begin
              done       = 1'b1;
              phase_next = PH_IDLE;
              take       = 1'b1;
            end
          end
          default: ;
        endcase
      end else if (held_valid) begin
        drop = 1'b1;
      end else begin
        held_pixel_next = q_item.pixel;
        held_last_next  = q_item.last;
        held_valid_next = 1'b1;
        if (phase == PH_IDLE) take = 1'b1;
      end
      // held pixel moves into the shifter and its first high phase starts
      if (take && held_valid_next) begin
        shift_bits_next   = held_pixel_next;
        current_last_next = held_last_next;
        held_valid_next   = 1'b0;
        bits_left_next    = LEFT_WIDTH'(PIX_BITS);
        phase_next        = PH_HIGH;
        tick_count_next   = '0;
      end
    end
    res.pin_level  = (phase_next == PH_HIGH);
    res.ready_res  = !held_valid_next;
    res.frame_done = done;
    res.dropped    = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks  <= LONG_RESET;
      short_ticks <= SHORT_RESET;
      latch_ticks <= LATCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG:  long_ticks  <= cfg_data;
        REG_SHORT: short_ticks <= cfg_data;
        REG_LATCH: latch_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits   <= '0;
      bits_left    <= '0;
      phase        <= PH_IDLE;
      tick_count   <= '0;
      held_valid   <= 1'b0;
      held_last    <= 1'b0;
      current_last <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      shift_bits   <= shift_bits_next;
      bits_left    <= bits_left_next;
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      held_valid   <= held_valid_next;
      held_last    <= held_last_next;
      current_last <= current_last_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_pixel <= held_pixel_next;
    if (pop) begin
      out_res <= res;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (!held_valid && (tick_count == '0)))
    else $error("idle shifter with a held pixel or running count");

  a_no_bits_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_LATCH) |-> (bits_left == '0))
    else $error("bits left outside a pixel");

  a_done_not_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.frame_done && out_res.dropped))
    else $error("result both frame end and drop");

endmodule

>>> hdl/rgb_led_pulse_width_serializer_unit.sv
// One-wire RGB LED serializer. Each item is either a timer tick (kind 0) or a pixel
// (kind 1); each gives exactly one result carrying the data line level after it,
// holding-buffer status, an end-of-latch flag and a drop flag. Pixels go out green,
// red, blue, MSB first: a one is long_ticks high then short_ticks low, a zero is
// short_ticks high then long_ticks low; after a last pixel the line stays low for
// latch_ticks. One item is taken every clock unless the output stalls; an accepted
// item passes through the input register and the two-entry queue, and its result is
// presented from the result register; items wait in the queue while the output stalls.
// The per-item update is one counter increment and compare plus a shift, done
// combinationally in the back end. Registers (long, short, latch ticks at indexes
// 0, 1, 2) reset to 64, 32, 4000; the user must write them only while no item is in
// flight, which the block itself does not enforce.
module rgb_led_pulse_width_serializer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic [7:0]  blue,
  input  logic        last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pin_level,
  output logic        ready_res,
  output logic        frame_done,
  output logic        dropped
);
  import rlpws_pkg::*;

  logic    push;
  item_t   push_item;
  logic    push_ready;
  logic    q_valid;
  item_t   q_item;
  logic    pop;
  result_t out_res;

  rlpws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .green      (green),
    .red        (red),
    .blue       (blue),
    .last_pixel (last_pixel),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  rlpws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (pop)
  );

  rlpws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign pin_level  = out_res.pin_level;
  assign ready_res  = out_res.ready_res;
  assign frame_done = out_res.frame_done;
  assign dropped    = out_res.dropped;

endmodule

>>> bench/led_frame_checker.sv
`timescale 1ns / 100ps
module led_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic [7:0]  blue,
  input  logic        last_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        pin_level,
  input  logic        ready_res,
  input  logic        frame_done,
  input  logic        dropped,
  output int          mismatch_count,
  output int          results_owed
);
  import rlpws_pkg::*;

  logic [CFG_WIDTH-1:0]   long_cfg, short_cfg, latch_cfg;
  logic [PIX_BITS-1:0]    shreg, hold_pix;
  logic [LEFT_WIDTH-1:0]  bits_rem;
  logic [COUNT_WIDTH-1:0] ticks;
  phase_t                 ph;
  logic                   hold_full, hold_last, cur_last;

  result_t expected_results[$];
  result_t want, got;

  function automatic void promote_held();
    if (!hold_full) return;
    shreg     = hold_pix;
    cur_last  = hold_last;
    hold_full = 1'b0;
    bits_rem  = LEFT_WIDTH'(PIX_BITS);
    ph        = PH_HIGH;
    ticks     = '0;
  endfunction

  // zero counts as one; durations past the counter range stop at its max
  function automatic logic tick_expire(input logic [CFG_WIDTH-1:0] dur_cfg);
    logic [31:0] dur;
    dur = 32'(dur_cfg);
    if (dur == 32'd0) dur = 32'd1;
    if (dur > 32'(CNT_MAX)) dur = 32'(CNT_MAX);
    if (ticks != CNT_MAX) ticks = ticks + 1'b1;
    if (32'(ticks) >= dur) begin
      ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic step_timer();
    logic cur_bit;
    logic fin;
    cur_bit = shreg[PIX_BITS-1];
    fin = 1'b0;
    case (ph)
      PH_HIGH: begin
        if (tick_expire(cur_bit ? long_cfg : short_cfg)) ph = PH_LOW;
      end
      PH_LOW: begin
        if (tick_expire(cur_bit ? short_cfg : long_cfg)) begin
          shreg = shreg << 1;
          if (bits_rem != 0) bits_rem = bits_rem - 1'b1;
          if (bits_rem != 0) begin
            ph = PH_HIGH;
          end else if (cur_last) begin
            cur_last = 1'b0;
            if (latch_cfg == 0) begin
              fin = 1'b1;
              ph = PH_IDLE;
              promote_held();
            end else begin
              ph = PH_LATCH;
            end
          end else begin
            ph = PH_IDLE;
            promote_held();
          end
        end
      end
      PH_LATCH: begin
        if (tick_expire(latch_cfg)) begin
          fin = 1'b1;
          ph = PH_IDLE;
          promote_held();
        end
      end
      default: ;
    endcase
    return fin;
  endfunction

  function automatic result_t predict_result(input logic k, input logic [PIX_BITS-1:0] pix,
                                             input logic lst);
    result_t res;
    logic fin, drop;
    fin = 1'b0;
    drop = 1'b0;
    if (k == KIND_TICK) begin
      fin = step_timer();
    end else if (hold_full) begin
      drop = 1'b1;
    end else begin
      hold_pix  = pix;
      hold_last = lst;
      hold_full = 1'b1;
      if (ph == PH_IDLE) promote_held();
    end
    res.pin_level  = (ph == PH_HIGH);
    res.ready_res  = !hold_full;
    res.frame_done = fin;
    res.dropped    = drop;
    return res;
  endfunction

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      long_cfg  = LONG_RESET;
      short_cfg = SHORT_RESET;
      latch_cfg = LATCH_RESET;
      shreg     = '0;
      hold_pix  = '0;
      bits_rem  = '0;
      ticks     = '0;
      ph        = PH_IDLE;
      hold_full = 1'b0;
      hold_last = 1'b0;
      cur_last  = 1'b0;
      expected_results.delete();
      mismatch_count = 0;
      results_owed   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG:  long_cfg  = cfg_data;
          REG_SHORT: short_cfg = cfg_data;
          REG_LATCH: latch_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_result(kind, {green, red, blue}, last_pixel));
      if (out_valid && out_ready) begin
        got = '{pin_level, ready_res, frame_done, dropped};
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected none, got %b", $time, got);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pin_level", want.pin_level, got.pin_level);
          check_field("ready_res", want.ready_res, got.ready_res);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("dropped", want.dropped, got.dropped);
        end
      end
      results_owed = expected_results.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rlpws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [7:0]  green, red, blue;
  logic        last_pixel;
  logic        out_valid;
  logic        out_ready;
  logic        pin_level, ready_res, frame_done, dropped;
  int          mismatch_count;
  int          results_owed;
  int unsigned cycle_count = 0;

  rgb_led_pulse_width_serializer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .green      (green),
    .red        (red),
    .blue       (blue),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pin_level  (pin_level),
    .ready_res  (ready_res),
    .frame_done (frame_done),
    .dropped    (dropped)
  );

  led_frame_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .green          (green),
    .red            (red),
    .blue           (blue),
    .last_pixel     (last_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pin_level      (pin_level),
    .ready_res      (ready_res),
    .frame_done     (frame_done),
    .dropped        (dropped),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: ready runs of random length broken by short stalls
  initial begin : receiver
    int run_len;
    int stall_len;
    out_ready = 1'b0;
    forever begin
      run_len = ($urandom_range(9) == 0) ? 60 : $urandom_range(10, 1);
      repeat (run_len) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      stall_len = $urandom_range(8, 1);
      repeat (stall_len) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic k, input logic [7:0] g, input logic [7:0] r,
                           input logic [7:0] b, input logic lst);
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= k;
    green      <= g;
    red        <= r;
    blue       <= b;
    last_pixel <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold off until every item has produced its result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] long_t, input logic [15:0] short_t,
                            input logic [15:0] latch_t);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG;
    cfg_data  <= long_t;
    @(negedge clk);
    cfg_index <= REG_SHORT;
    cfg_data  <= short_t;
    @(negedge clk);
    cfg_index <= REG_LATCH;
    cfg_data  <= latch_t;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_color();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic run_phase(input int n_items, input int pixel_pct);
    int sent;
    int burst;
    int gap;
    logic k;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(7) == 0) ? 40 : $urandom_range(12, 1);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        k = ($urandom_range(99) < pixel_pct) ? KIND_PIXEL : KIND_TICK;
        send_item(k, pick_color(), pick_color(), pick_color(), $urandom_range(3) == 0);
        sent++;
        if (sent == n_items / 2) drain();
      end
      gap = $urandom_range(6);
      if (gap != 0) idle_gap(gap);
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_LONG;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = KIND_TICK;
    green      = '0;
    red        = '0;
    blue       = '0;
    last_pixel = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset timing: idle tick, start, hold, refuse when full
    send_item(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_item(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1);
    send_item(KIND_PIXEL, 8'h80, 8'h01, 8'h7F, 1'b1);
    repeat (4) send_item(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain();

    set_timing(16'd0, 16'd0, 16'd0);
    run_phase(250, 3);
    drain();
    set_timing(16'd1, 16'd1, 16'd1);
    run_phase(200, 3);
    drain();
    set_timing(16'd2, 16'd1, 16'd5);
    run_phase(250, 2);
    drain();
    set_timing(16'd1, 16'd3, 16'd0);
    run_phase(200, 2);
    drain();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(100, 2);
    drain();
    set_timing(16'd3, 16'd2, 16'd20);
    run_phase(250, 1);
    drain();
    set_timing(16'd1, 16'd2, 16'd3);
    run_phase(100, 5);
    drain();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rlpws_pkg.sv
hdl/rlpws_front.sv
hdl/rlpws_queue.sv
hdl/rlpws_back.sv
hdl/rgb_led_pulse_width_serializer_unit.sv
bench/led_frame_checker.sv
bench/tb_top.sv
